### design/rsi_pkg.sv
// Shared types and constants for the relative strength index unit.
// Has no dependencies; every other file in the design imports it.
package rsi_pkg;

  localparam int PRICE_WIDTH   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int AVG_W         = 56;
  localparam int ACC_W         = 64;
  localparam int DVS_W         = 57;
  localparam int CNT_W         = 9;
  localparam int RSI_W         = 14;
  localparam int WIN_W         = 8;

  localparam logic [CNT_W-1:0] STEADY_MARK = 9'd256;
  localparam logic [RSI_W-1:0] RSI_SCALE   = 14'd10000;
  localparam logic [WIN_W-1:0] WIN_RESET   = 8'd14;
  localparam logic [WIN_W-1:0] WIN_MIN     = 8'd2;

  // One classified request passed from the front to the back.
  typedef struct packed {
    logic                   restart;
    logic [PRICE_WIDTH-1:0] gain;
    logic [PRICE_WIDTH-1:0] loss;
  } rsi_entry_t;

endpackage

### design/relative_strength_index_unit.sv
// Relative strength index unit (Wilder smoothing), top level.
// Depends on rsi_pkg, rsi_front, rsi_fifo and rsi_back.
//
// Prices enter on the s_axis channel: tdata carries the price and tuser the
// new-series flag. Results leave on the m_axis channel: tdata carries the
// index in hundredths of a percent and tuser the undefined flag.
// The user must write the window length N through cfg_we_i/cfg_wdata_i only
// while idle; the block itself does not enforce this. The first price of a
// series and warm-up changes give no result; from the (N+1)-th price on every
// price gives one result. The change ending warm-up runs the divide and then
// the index multiply and divide; a smoothing change runs the shift-add multiply,
// the divide, the index multiply and the index divide. The two 64-step divider
// lanes work one quotient bit a cycle.
// A two-entry queue lets the front take prices while the back is busy;
// the output register holds a result while the receiver stalls, and the
// back waits for it before loading the next one.
// Reset clears the stored series and sets N to 14.
module relative_strength_index_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // [31:0] price
  input  logic        s_axis_tuser,  // [0] new_series
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [13:0] rsi_hundredths, zero fill above
  output logic        m_axis_tuser   // [0] undefined
);
  import rsi_pkg::*;

  logic [WIN_W-1:0] win_q;
  logic             push, full, q_valid, pop;
  rsi_entry_t       wr_entry, rd_entry;
  logic [RSI_W-1:0] rsi;

  // Window length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= WIN_RESET;
    end else if (cfg_we_i) begin
      win_q <= cfg_wdata_i;
    end
  end

  rsi_front u_front (
    .clk_i, .rst_ni, .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .price_i(s_axis_tdata[PRICE_WIDTH-1:0]), .new_series_i(s_axis_tuser),
    .push_o(push), .entry_o(wr_entry), .full_i(full)
  );

  rsi_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .wdata_i(wr_entry), .full_o(full),
    .pop_i(pop), .valid_o(q_valid), .rdata_o(rd_entry)
  );

  rsi_back u_back (
    .clk_i, .rst_ni, .win_i(win_q), .valid_i(q_valid), .entry_i(rd_entry),
    .pop_o(pop), .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .rsi_o(rsi), .undefined_o(m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, rsi};

endmodule

### design/rsi_fifo.sv
// Two-entry request queue between the front and back parts.
// Depends on rsi_pkg for the entry type.
module rsi_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rsi_pkg::rsi_entry_t wdata_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output rsi_pkg::rsi_entry_t rdata_o
);
  import rsi_pkg::*;

  rsi_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  // Storage is written only on a push.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      if (push_i && !pop_i)      count_q <= count_q + 2'd1;
      else if (pop_i && !push_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

### design/rsi_front.sv
// Front part: takes prices, keeps the previous one and splits each change
// into gain and loss. Depends on rsi_pkg.
module rsi_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [rsi_pkg::PRICE_WIDTH-1:0] price_i,
  input  logic                            new_series_i,
  output logic                            push_o,
  output rsi_pkg::rsi_entry_t             entry_o,
  input  logic                            full_i
);
  import rsi_pkg::*;

  logic [PRICE_WIDTH-1:0] last_q;
  logic                   have_q;
  logic                   rise;

  assign ready_o = ~full_i;
  assign push_o  = valid_i & ~full_i;
  assign rise    = price_i > last_q;

  // Classify the request: restart, or a change split into its parts.
  always_comb begin
    entry_o.restart = new_series_i | ~have_q;
    entry_o.gain    = rise ? price_i - last_q : '0;
    entry_o.loss    = rise ? '0 : last_q - price_i;
  end

  always_ff @(posedge clk_i) begin
    if (push_o) last_q <= price_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (push_o) begin
      have_q <= 1'b1;
    end
  end

endmodule

### design/rsi_div.sv
// Iterative restoring divider, one quotient bit per cycle, 64 steps.
// Depends on rsi_pkg for widths.
module rsi_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rsi_pkg::ACC_W-1:0] dividend_i,
  input  logic [rsi_pkg::DVS_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [rsi_pkg::ACC_W-1:0] quotient_o
);
  import rsi_pkg::*;

  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W-1:0] rem_q;
  logic [ACC_W-1:0] quo_q;
  logic [6:0]       cnt_q;
  logic             busy_q;
  logic [DVS_W:0]   trial;
  logic             fits;

  assign trial      = {rem_q, quo_q[ACC_W-1]};
  assign fits       = trial >= {1'b0, dvs_q};
  assign quotient_o = quo_q;

  // Datapath: shift the dividend through, subtracting where it fits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q <= divisor_i;
      rem_q <= '0;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
      quo_q <= {quo_q[ACC_W-2:0], fits};
    end
  end

  // Step counter; done pulses after the last step.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'(ACC_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

endmodule

### design/rsi_back.sv
// Back part: keeps the warm-up sums and Wilder averages and works out the
// index with shift-add multiplies and two divider lanes. Depends on rsi_pkg, rsi_div.
module rsi_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [rsi_pkg::WIN_W-1:0]       win_i,
  input  logic                            valid_i,
  input  rsi_pkg::rsi_entry_t             entry_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [rsi_pkg::RSI_W-1:0]       rsi_o,
  output logic                            undefined_o
);
  import rsi_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_RMUL = 3'd4;
  localparam logic [2:0] ST_RDIV = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  logic [2:0]       state_q;
  logic [CNT_W-1:0] cnt_q;
  logic [AVG_W-1:0] g_q, l_q, g_sum, l_sum;
  logic [ACC_W-1:0] accg_q, accl_q, mg_q, ml_q;
  logic [RSI_W-1:0] mult_q;
  logic [3:0]       step_q;
  logic [ACC_W-1:0] dvd0_q, dvd1_q;
  logic [DVS_W-1:0] dvs_q, total;
  logic             start_q;
  logic             done0, done1;
  logic [ACC_W-1:0] quo0, quo1;
  logic [RSI_W-1:0] rsi_q;
  logic             undef_q;
  logic             out_valid_q;
  logic [WIN_W-1:0] n;

  assign n      = (win_i < WIN_MIN) ? WIN_MIN : win_i;
  assign pop_o  = valid_i && (state_q == ST_IDLE);
  assign g_sum  = g_q + AVG_W'(entry_i.gain);
  assign l_sum  = l_q + AVG_W'(entry_i.loss);
  assign total  = DVS_W'(g_q) + DVS_W'(l_q);
  assign out_valid_o = out_valid_q;

  rsi_div u_div_gain (
    .clk_i, .rst_ni, .start_i(start_q), .dividend_i(dvd0_q), .divisor_i(dvs_q),
    .done_o(done0), .quotient_o(quo0)
  );

  rsi_div u_div_loss (
    .clk_i, .rst_ni, .start_i(start_q), .dividend_i(dvd1_q), .divisor_i(dvs_q),
    .done_o(done1), .quotient_o(quo1)
  );

  // Sequencer and arithmetic registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      g_q         <= '0;
      l_q         <= '0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      accg_q <= '0; accl_q <= '0; mg_q <= '0; ml_q <= '0;
      mult_q <= '0; step_q <= '0; dvd0_q <= '0; dvd1_q <= '0; dvs_q <= '0;
      rsi_q  <= '0; undef_q <= 1'b0;
      rsi_o  <= '0; undefined_o <= 1'b0;
    end else begin
      start_q <= 1'b0;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            if (entry_i.restart) begin
              cnt_q <= CNT_W'(1);
              g_q   <= '0;
              l_q   <= '0;
            end else if (cnt_q < STEADY_MARK) begin
              // Warm-up: sum, and at the N-th change scale and divide.
              g_q <= g_sum;
              l_q <= l_sum;
              if (cnt_q < CNT_W'(n)) begin
                cnt_q <= cnt_q + CNT_W'(1);
              end else begin
                dvd0_q  <= ACC_W'(g_sum) << FRACTION_BITS;
                dvd1_q  <= ACC_W'(l_sum) << FRACTION_BITS;
                dvs_q   <= DVS_W'(n);
                start_q <= 1'b1;
                state_q <= ST_DIV;
              end
            end else begin
              // Smoothing: avg*(N-1) plus the scaled part, serially.
              accg_q  <= ACC_W'(entry_i.gain) << FRACTION_BITS;
              accl_q  <= ACC_W'(entry_i.loss) << FRACTION_BITS;
              mg_q    <= ACC_W'(g_q);
              ml_q    <= ACC_W'(l_q);
              mult_q  <= RSI_W'(n - WIN_W'(1));
              step_q  <= 4'(WIN_W);
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (mult_q[0]) begin
            accg_q <= accg_q + mg_q;
            accl_q <= accl_q + ml_q;
          end
          mg_q   <= mg_q << 1;
          ml_q   <= ml_q << 1;
          mult_q <= mult_q >> 1;
          step_q <= step_q - 4'd1;
          if (step_q == 4'd1) begin
            dvd0_q  <= accg_q + (mult_q[0] ? mg_q : '0);
            dvd1_q  <= accl_q + (mult_q[0] ? ml_q : '0);
            dvs_q   <= DVS_W'(n);
            start_q <= 1'b1;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (done0 && done1) begin
            g_q     <= quo0[AVG_W-1:0];
            l_q     <= quo1[AVG_W-1:0];
            cnt_q   <= STEADY_MARK;
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          if (total == '0) begin
            rsi_q   <= '0;
            undef_q <= 1'b1;
            state_q <= ST_EMIT;
          end else begin
            accg_q  <= '0;
            mg_q    <= ACC_W'(g_q);
            mult_q  <= RSI_SCALE;
            step_q  <= 4'(RSI_W);
            dvs_q   <= total;
            state_q <= ST_RMUL;
          end
        end
        ST_RMUL: begin
          if (mult_q[0]) accg_q <= accg_q + mg_q;
          mg_q   <= mg_q << 1;
          mult_q <= mult_q >> 1;
          step_q <= step_q - 4'd1;
          if (step_q == 4'd1) begin
            dvd0_q  <= accg_q + (mult_q[0] ? mg_q : '0);
            dvd1_q  <= '0;
            start_q <= 1'b1;
            state_q <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          if (done0) begin
            rsi_q   <= (quo0 > ACC_W'(RSI_SCALE)) ? RSI_SCALE : quo0[RSI_W-1:0];
            undef_q <= 1'b0;
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Load the output register once it is free or being emptied.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            rsi_o       <= rsi_q;
            undefined_o <= undef_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### dv/rsi_checker.sv
// Checker for the relative strength index unit: watches the price and result
// channels and the window register port, predicts each index and compares.
// Depends on rsi_pkg for widths; instantiated beside the block by the bench.
module rsi_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);
  import rsi_pkg::*;

  typedef struct packed {
    logic [RSI_W-1:0] rsi;
    logic             undef;
  } rsi_result_t;

  localparam logic [63:0] AVG_MASK = (64'd1 << AVG_W) - 64'd1;

  rsi_result_t         rsi_expected_q[$];
  logic [WIN_W-1:0]    win_len;
  logic [31:0]         prev_price;
  logic [CNT_W-1:0]    count;
  logic [63:0]         gain_avg, loss_avg;

  // Wilder smoothing step, 64-bit wrapping as in the block's datapath.
  function automatic logic [63:0] smooth(input logic [63:0] avg, input logic [63:0] part,
                                         input logic [63:0] n);
    logic [63:0] acc;
    acc = avg * (n - 64'd1) + (part << FRACTION_BITS);
    return (acc / n) & AVG_MASK;
  endfunction

  // Advances the series by one price; returns 1 when an index is produced.
  function automatic bit advance_series(input logic [31:0] price, input logic restart,
                                        output rsi_result_t res);
    logic [63:0] n, up, down, total, pct;
    res = '0;
    n = (win_len < WIN_MIN) ? 64'(WIN_MIN) : 64'(win_len);
    if (restart || count == '0) begin
      prev_price = price;
      count = 9'd1;
      gain_avg = '0;
      loss_avg = '0;
      return 0;
    end
    up = (price > prev_price) ? 64'(price - prev_price) : 64'd0;
    down = (price > prev_price) ? 64'd0 : 64'(prev_price - price);
    prev_price = price;
    if (count < STEADY_MARK) begin
      gain_avg = (gain_avg + up) & AVG_MASK;
      loss_avg = (loss_avg + down) & AVG_MASK;
      if (64'(count) < n) begin
        count = count + 9'd1;
        return 0;
      end
      gain_avg = ((gain_avg << FRACTION_BITS) / n) & AVG_MASK;
      loss_avg = ((loss_avg << FRACTION_BITS) / n) & AVG_MASK;
      count = STEADY_MARK;
    end else begin
      gain_avg = smooth(gain_avg, up, n);
      loss_avg = smooth(loss_avg, down, n);
    end
    total = gain_avg + loss_avg;
    if (total == '0) begin
      res.undef = 1'b1;
      return 1;
    end
    pct = (gain_avg * 64'd10000) / total;
    if (pct > 64'd10000) pct = 64'd10000;
    res.rsi = pct[RSI_W-1:0];
    return 1;
  endfunction

  assign pending_o = rsi_expected_q.size();

  // Register writes and accepted requests update the prediction; results are checked.
  always @(posedge clk_i or negedge rst_ni) begin
    rsi_result_t res, got;
    if (!rst_ni) begin
      win_len = WIN_RESET;
      prev_price = '0;
      count = '0;
      gain_avg = '0;
      loss_avg = '0;
      rsi_expected_q.delete();
      fail_count_o <= 0;
      result_count_o <= 0;
    end else begin
      if (cfg_we_i) win_len = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        if (advance_series(s_axis_tdata, s_axis_tuser, res)) rsi_expected_q.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.rsi = m_axis_tdata[RSI_W-1:0];
        got.undef = m_axis_tuser;
        result_count_o <= result_count_o + 1;
        if (rsi_expected_q.size() == 0) begin
          if (fail_count_o < 10) $display("Unexpected result: rsi %0d undefined %0b",
                                          got.rsi, got.undef);
          fail_count_o <= fail_count_o + 1;
        end else begin
          res = rsi_expected_q.pop_front();
          if (m_axis_tdata !== {2'b00, res.rsi} || m_axis_tuser !== res.undef) begin
            if (fail_count_o < 10)
              $display("Mismatch: expected rsi %0d undefined %0b, got tdata %0d undefined %0b",
                       res.rsi, res.undef, m_axis_tdata, m_axis_tuser);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

### dv/tb_relative_strength_index_unit.sv
// Bench top for the relative strength index unit: drives prices and window
// settings, stalls the result channel, and reports the checker's verdict.
// Depends on rsi_pkg, relative_strength_index_unit and rsi_checker.
module tb_relative_strength_index_unit;
  import rsi_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 400;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;

  int          fail_count, pending, result_count;
  int          cycles = 0;
  int          sent = 0;
  bit          calm = 1'b0;
  bit          hold_off = 1'b0;
  logic [31:0] walk_price = 32'd100000;

  relative_strength_index_unit i_dut (.*);

  rsi_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Cycle limit guards against a hung handshake.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: random stall bursts, one long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_axis_tready <= 1'b0;
        repeat (600) @(negedge clk_i);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 14);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offers one price request and holds it until accepted. The valid line is
  // dropped only for an idle gap or by the caller, so back-to-back requests
  // follow each other without a second update in the same time step.
  task automatic send_price(input logic [31:0] price, input logic restart);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= price;
    s_axis_tuser <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent++;
  endtask

  // Waits until the block is idle, then writes the window length.
  task automatic set_window(input logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One random-walk price; now and then a jump across the whole range.
  task automatic send_walk(input int restart_odds);
    int pick;
    logic [31:0] step;
    pick = $urandom_range(0, 19);
    step = $urandom_range(0, 2000);
    if (pick == 0) walk_price = $urandom();
    else if (pick < 3) walk_price = walk_price;
    else if (pick < 11) walk_price = walk_price + step;
    else walk_price = walk_price - step;
    send_price(walk_price, $urandom_range(0, restart_odds) == 0);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Short window: extremes, flat prices, pure rises and falls.
    set_window(8'd2);
    send_price(32'd0, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'd0, 1'b0);
    send_price(32'hFFFF_FFFF, 1'b0);
    send_price(32'd7, 1'b1);
    send_price(32'd7, 1'b0);
    send_price(32'd7, 1'b0);
    send_price(32'd7, 1'b0);
    send_price(32'd10, 1'b1);
    send_price(32'd20, 1'b0);
    send_price(32'd30, 1'b0);
    send_price(32'd40, 1'b0);
    send_price(32'd40, 1'b0);
    send_price(32'd5, 1'b0);
    send_price(32'd0, 1'b0);

    // Windows of zero and one behave as two.
    set_window(8'd0);
    send_price(32'd100, 1'b1);
    send_price(32'd90, 1'b0);
    send_price(32'd95, 1'b0);
    set_window(8'd1);
    send_price(32'd99, 1'b0);
    send_price(32'd80, 1'b0);

    // Window shortened during warm-up ends it at the new length.
    set_window(8'd6);
    send_price(32'd500, 1'b1);
    send_price(32'd510, 1'b0);
    send_price(32'd505, 1'b0);
    set_window(8'd2);
    send_price(32'd520, 1'b0);
    send_price(32'd530, 1'b0);

    // Random phases across several window settings, the extremes among them.
    set_window(8'd14);
    repeat (150) send_walk(60);

    // Long hold-off on the result side while prices keep coming.
    hold_off = 1'b1;
    repeat (30) send_walk(1000);

    set_window(8'd255);
    send_price($urandom(), 1'b1);
    repeat (300) send_walk(100000);

    set_window(8'd3);
    repeat (200) send_walk(25);

    set_window(8'($urandom_range(2, 255)));
    repeat (150) send_walk(80);

    set_window(8'd5);
    repeat (100) send_walk(40);

    // Closing stretch without idling on either side.
    calm = 1'b1;
    repeat (90) send_walk(50);
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Run covered %0d prices and %0d results over windows 0 to 255,", sent,
             result_count);
    $display("with restarts, flat series, full-range jumps and result-side stalls.");
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
